@@ hdl/capsule_ball_contact_circle_top_defines.svh @@
// assertion macros for the ball against capsule contact block
// needs a clock named clk and an active-low reset named rst_n in the using module
`ifndef CAPSULE_BALL_CONTACT_CIRCLE_TOP_DEFINES_SVH
`define CAPSULE_BALL_CONTACT_CIRCLE_TOP_DEFINES_SVH

// consequence in the same cycle
`define CBCC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the next cycle
`define CBCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cbcc_pkg.sv @@
// shared constants and types for the ball against capsule contact block
// no dependencies
package cbcc_pkg;

    // default fixed point format
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // stream widths
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 120;
    localparam int OUT_USED_W  = 113;

    // configuration port
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_REGS   = 7;

    // register indexes
    typedef enum logic [2:0] {
        REG_END_A    = 3'd0,
        REG_END_B    = 3'd1,
        REG_RADII    = 3'd2,
        REG_T1_START = 3'd3,
        REG_T1_END   = 3'd4,
        REG_T2_START = 3'd5,
        REG_T2_END   = 3'd6
    } reg_idx_t;

    // how a projection parameter is settled
    typedef enum logic [1:0] {
        PROJ_DIVIDE = 2'd0,
        PROJ_ZERO   = 2'd1,
        PROJ_ONE    = 2'd2
    } proj_mode_t;

endpackage

@@ hdl/capsule_ball_contact_circle_top.sv @@
// ball against tapered capsule contact circle, fully pipelined
// depends on cbcc_pkg and capsule_ball_contact_circle_top_defines.svh
//
//  channel   | dir | fields (lsb first)
//  s_axis    | in  | ball_x[31:0] ball_y[63:32] ball_r[94:64]
//  m_axis    | out | hit[0] circle_x[32:1] circle_y[64:33] circle_r[95:65] axis_param[112:96]
//  apb       | in  | seven 64-bit registers at byte address 8*i
//
// one request per cycle while the output is not stalled; the pipeline depth is
// set mostly by the two restoring divisions of FRAC_BITS one-bit stages each
// each stage holds while the one after it is full and stalled, so bubbles close up
// and a request is taken while a finished result waits on m_tready
// rst_n clears the valid bits and the registers; data stages need no reset
`include "capsule_ball_contact_circle_top_defines.svh"

module capsule_ball_contact_circle_top #(
    parameter int COORD_WIDTH = cbcc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = cbcc_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // ball_x[31:0], ball_y[63:32], ball_r[94:64], zero pad
    input  logic [cbcc_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // hit[0], circle_x[32:1], circle_y[64:33], circle_r[95:65], axis_param[112:96]
    output logic [cbcc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cbcc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [cbcc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cbcc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DFW = W + 1;
    localparam int PRW = 2 * DFW;
    localparam int NMW = PRW + 1;
    localparam int QW  = F + 1;
    localparam int SPW = DFW + QW + 1;
    localparam int RQW = W + QW + 1;
    localparam logic [QW-1:0] ONE = QW'(1) << F;

    localparam int S_IN  = 0;
    localparam int S_D1  = 1;
    localparam int S_M1  = 2;
    localparam int S_N1  = 3;
    localparam int S_Q1  = S_N1 + F;
    localparam int S_P1  = S_Q1 + 1;
    localparam int S_P2  = S_P1 + 1;
    localparam int S_P3  = S_P2 + 1;
    localparam int S_SEL = S_P3 + 1;
    localparam int S_D3  = S_SEL + 1;
    localparam int S_M3  = S_D3 + 1;
    localparam int S_N3  = S_M3 + 1;
    localparam int S_Q3  = S_N3 + F;
    localparam int S_P4  = S_Q3 + 1;
    localparam int S_P5  = S_P4 + 1;
    localparam int S_P6  = S_P5 + 1;
    localparam int S_OUT = S_P6 + 1;
    localparam int NST   = S_OUT + 1;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [cbcc_pkg::CFG_DATA_W-1:0] cfg_reg [0:cbcc_pkg::NUM_REGS-1];
    cbcc_pkg::reg_idx_t              cfg_idx;
    logic                            cfg_we;

    assign cfg_idx = cbcc_pkg::reg_idx_t'(paddr[cbcc_pkg::CFG_ADDR_W-1:3]);
    assign cfg_we  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cbcc_pkg::NUM_REGS; i++)
                cfg_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                cbcc_pkg::REG_END_A, cbcc_pkg::REG_END_B, cbcc_pkg::REG_RADII,
                cbcc_pkg::REG_T1_START, cbcc_pkg::REG_T1_END,
                cbcc_pkg::REG_T2_START, cbcc_pkg::REG_T2_END:
                    cfg_reg[cfg_idx] <= pwdata;
                default: ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        case (cfg_idx)
            cbcc_pkg::REG_END_A, cbcc_pkg::REG_END_B, cbcc_pkg::REG_RADII,
            cbcc_pkg::REG_T1_START, cbcc_pkg::REG_T1_END,
            cbcc_pkg::REG_T2_START, cbcc_pkg::REG_T2_END:
                prdata = cfg_reg[cfg_idx];
            default:
                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // geometry from the registers; index 0, 1 tangents, 2 axis
    // ---------------------------------------------------------------
    logic signed [W-1:0]   seg_sx [0:2];
    logic signed [W-1:0]   seg_sy [0:2];
    logic signed [W-1:0]   seg_ex [0:2];
    logic signed [W-1:0]   seg_ey [0:2];
    logic signed [DFW-1:0] seg_abx [0:2];
    logic signed [DFW-1:0] seg_aby [0:2];
    logic [W-2:0]          rad_a;
    logic [W-2:0]          rad_b;
    logic signed [W-1:0]   rad_diff;

    assign seg_sx[0] = $signed(cfg_reg[cbcc_pkg::REG_T1_START][W-1:0]);
    assign seg_sy[0] = $signed(cfg_reg[cbcc_pkg::REG_T1_START][32+W-1:32]);
    assign seg_ex[0] = $signed(cfg_reg[cbcc_pkg::REG_T1_END][W-1:0]);
    assign seg_ey[0] = $signed(cfg_reg[cbcc_pkg::REG_T1_END][32+W-1:32]);
    assign seg_sx[1] = $signed(cfg_reg[cbcc_pkg::REG_T2_START][W-1:0]);
    assign seg_sy[1] = $signed(cfg_reg[cbcc_pkg::REG_T2_START][32+W-1:32]);
    assign seg_ex[1] = $signed(cfg_reg[cbcc_pkg::REG_T2_END][W-1:0]);
    assign seg_ey[1] = $signed(cfg_reg[cbcc_pkg::REG_T2_END][32+W-1:32]);
    assign seg_sx[2] = $signed(cfg_reg[cbcc_pkg::REG_END_A][W-1:0]);
    assign seg_sy[2] = $signed(cfg_reg[cbcc_pkg::REG_END_A][32+W-1:32]);
    assign seg_ex[2] = $signed(cfg_reg[cbcc_pkg::REG_END_B][W-1:0]);
    assign seg_ey[2] = $signed(cfg_reg[cbcc_pkg::REG_END_B][32+W-1:32]);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            seg_abx[i] = DFW'(seg_ex[i]) - DFW'(seg_sx[i]);
            seg_aby[i] = DFW'(seg_ey[i]) - DFW'(seg_sy[i]);
        end
    end

    // end radii saturate at the largest positive coordinate
    assign rad_a = cfg_reg[cbcc_pkg::REG_RADII][W-1] ? {(W-1){1'b1}}
                                                     : cfg_reg[cbcc_pkg::REG_RADII][W-2:0];
    assign rad_b = cfg_reg[cbcc_pkg::REG_RADII][32+W-1] ? {(W-1){1'b1}}
                                                        : cfg_reg[cbcc_pkg::REG_RADII][32+W-2:32];
    assign rad_diff = $signed({1'b0, rad_b}) - $signed({1'b0, rad_a});

    // squared segment lengths, refreshed every cycle from the registers
    logic signed [PRW-1:0] den_px_reg [0:2];
    logic signed [PRW-1:0] den_py_reg [0:2];
    logic [NMW-1:0]        den_reg [0:2];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            den_px_reg[i] <= seg_abx[i] * seg_abx[i];
            den_py_reg[i] <= seg_aby[i] * seg_aby[i];
            den_reg[i]    <= NMW'($unsigned(den_px_reg[i])) + NMW'($unsigned(den_py_reg[i]));
        end
    end

    // ---------------------------------------------------------------
    // pipeline flow: a stage loads when empty or when the next one loads
    // ---------------------------------------------------------------
    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    always_comb
    begin
        rdy[NST] = m_tready;
        for (int k = NST - 1; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[S_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // projection mode from dot product and squared length
    function automatic cbcc_pkg::proj_mode_t proj_mode(logic signed [NMW-1:0] num,
                                                       logic [NMW-1:0] den);
        cbcc_pkg::proj_mode_t m;
        if (den == '0 || num[NMW-1] || num == '0)
            m = cbcc_pkg::PROJ_ZERO;
        else if ($unsigned(num) >= den)
            m = cbcc_pkg::PROJ_ONE;
        else
            m = cbcc_pkg::PROJ_DIVIDE;
        return m;
    endfunction

    // settled parameter from mode and quotient
    function automatic logic [QW-1:0] proj_t(cbcc_pkg::proj_mode_t m, logic [QW-1:0] q);
        logic [QW-1:0] t;
        case (m)
            cbcc_pkg::PROJ_ZERO: t = '0;
            cbcc_pkg::PROJ_ONE:  t = ONE;
            default:             t = q;
        endcase
        return t;
    endfunction

    // ---------------------------------------------------------------
    // ball carried down the pipe
    // ---------------------------------------------------------------
    logic signed [W-1:0] px_reg [0:S_P5];
    logic signed [W-1:0] py_reg [0:S_P5];
    logic [W-2:0]        pr_reg [0:S_P5];

    always_ff @(posedge clk)
    begin
        if (rdy[S_IN])
        begin
            px_reg[S_IN] <= $signed(s_tdata[W-1:0]);
            py_reg[S_IN] <= $signed(s_tdata[32+W-1:32]);
            pr_reg[S_IN] <= s_tdata[64+W-2:64];
        end
        for (int k = 1; k <= S_P5; k++)
            if (rdy[k])
            begin
                px_reg[k] <= px_reg[k-1];
                py_reg[k] <= py_reg[k-1];
                pr_reg[k] <= pr_reg[k-1];
            end
    end

    // ---------------------------------------------------------------
    // tangent projections: offsets, products, dot and mode
    // ---------------------------------------------------------------
    logic signed [DFW-1:0] t_cdx_reg [0:1];
    logic signed [DFW-1:0] t_cdy_reg [0:1];
    logic signed [PRW-1:0] t_mx_reg [0:1];
    logic signed [PRW-1:0] t_my_reg [0:1];
    logic signed [NMW-1:0] t_num [0:1];

    logic [NMW-1:0]        t_r_reg [0:F][0:1];
    logic [QW-1:0]         t_q_reg [0:F][0:1];
    cbcc_pkg::proj_mode_t  t_m_reg [0:F][0:1];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
            t_num[i] = NMW'(t_mx_reg[i]) + NMW'(t_my_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (rdy[S_D1])
            begin
                t_cdx_reg[i] <= DFW'(px_reg[S_IN]) - DFW'(seg_sx[i]);
                t_cdy_reg[i] <= DFW'(py_reg[S_IN]) - DFW'(seg_sy[i]);
            end
            if (rdy[S_M1])
            begin
                t_mx_reg[i] <= t_cdx_reg[i] * seg_abx[i];
                t_my_reg[i] <= t_cdy_reg[i] * seg_aby[i];
            end
            if (rdy[S_N1])
            begin
                t_r_reg[0][i] <= $unsigned(t_num[i]);
                t_q_reg[0][i] <= '0;
                t_m_reg[0][i] <= proj_mode(t_num[i], den_reg[i]);
            end
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < F; j++)
    begin : g_tdiv
        for (genvar i = 0; i < 2; i++)
        begin : g_lane
            logic [NMW-1:0] sh;
            logic           ge;

            assign sh = {t_r_reg[j][i][NMW-2:0], 1'b0};
            assign ge = sh >= den_reg[i];

            always_ff @(posedge clk)
            begin
                if (rdy[S_N1+1+j])
                begin
                    t_r_reg[j+1][i] <= ge ? sh - den_reg[i] : sh;
                    t_q_reg[j+1][i] <= {t_q_reg[j][i][QW-2:0], ge};
                    t_m_reg[j+1][i] <= t_m_reg[j][i];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tangent points and squared distances, pick the nearer
    // ---------------------------------------------------------------
    logic signed [SPW-1:0] t_pxq_reg [0:1];
    logic signed [SPW-1:0] t_pyq_reg [0:1];
    logic signed [W-1:0]   pt_x [0:1];
    logic signed [W-1:0]   pt_y [0:1];
    logic signed [W-1:0]   pt_x_reg [0:1];
    logic signed [W-1:0]   pt_y_reg [0:1];
    logic signed [W-1:0]   pt_x3_reg [0:1];
    logic signed [W-1:0]   pt_y3_reg [0:1];
    logic signed [DFW-1:0] ed_x_reg [0:1];
    logic signed [DFW-1:0] ed_y_reg [0:1];
    logic signed [PRW-1:0] sq_x_reg [0:1];
    logic signed [PRW-1:0] sq_y_reg [0:1];
    logic [PRW-1:0]        dist_t [0:1];
    logic signed [QW:0]    t_qs [0:1];
    logic signed [W-1:0]   c_x_reg;
    logic signed [W-1:0]   c_y_reg;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            t_qs[i]   = $signed({1'b0, proj_t(t_m_reg[F][i], t_q_reg[F][i])});
            pt_x[i]   = W'(DFW'(seg_sx[i]) + DFW'(t_pxq_reg[i] >>> F));
            pt_y[i]   = W'(DFW'(seg_sy[i]) + DFW'(t_pyq_reg[i] >>> F));
            dist_t[i] = $unsigned(sq_x_reg[i]) + $unsigned(sq_y_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (rdy[S_P1])
            begin
                t_pxq_reg[i] <= seg_abx[i] * t_qs[i];
                t_pyq_reg[i] <= seg_aby[i] * t_qs[i];
            end
            if (rdy[S_P2])
            begin
                pt_x_reg[i] <= pt_x[i];
                pt_y_reg[i] <= pt_y[i];
                ed_x_reg[i] <= DFW'(px_reg[S_P1]) - DFW'(pt_x[i]);
                ed_y_reg[i] <= DFW'(py_reg[S_P1]) - DFW'(pt_y[i]);
            end
            if (rdy[S_P3])
            begin
                pt_x3_reg[i] <= pt_x_reg[i];
                pt_y3_reg[i] <= pt_y_reg[i];
                sq_x_reg[i]  <= ed_x_reg[i] * ed_x_reg[i];
                sq_y_reg[i]  <= ed_y_reg[i] * ed_y_reg[i];
            end
        end
        // equal distances go to the second tangent
        if (rdy[S_SEL])
        begin
            c_x_reg <= (dist_t[0] < dist_t[1]) ? pt_x3_reg[0] : pt_x3_reg[1];
            c_y_reg <= (dist_t[0] < dist_t[1]) ? pt_y3_reg[0] : pt_y3_reg[1];
        end
    end

    // ---------------------------------------------------------------
    // axis projection of the chosen point
    // ---------------------------------------------------------------
    logic signed [DFW-1:0] a_cdx_reg;
    logic signed [DFW-1:0] a_cdy_reg;
    logic signed [PRW-1:0] a_mx_reg;
    logic signed [PRW-1:0] a_my_reg;
    logic signed [NMW-1:0] a_num;

    logic [NMW-1:0]        a_r_reg [0:F];
    logic [QW-1:0]         a_q_reg [0:F];
    cbcc_pkg::proj_mode_t  a_m_reg [0:F];

    assign a_num = NMW'(a_mx_reg) + NMW'(a_my_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[S_D3])
        begin
            a_cdx_reg <= DFW'(c_x_reg) - DFW'(seg_sx[2]);
            a_cdy_reg <= DFW'(c_y_reg) - DFW'(seg_sy[2]);
        end
        if (rdy[S_M3])
        begin
            a_mx_reg <= a_cdx_reg * seg_abx[2];
            a_my_reg <= a_cdy_reg * seg_aby[2];
        end
        if (rdy[S_N3])
        begin
            a_r_reg[0] <= $unsigned(a_num);
            a_q_reg[0] <= '0;
            a_m_reg[0] <= proj_mode(a_num, den_reg[2]);
        end
    end

    for (genvar j = 0; j < F; j++)
    begin : g_adiv
        logic [NMW-1:0] sh;
        logic           ge;

        assign sh = {a_r_reg[j][NMW-2:0], 1'b0};
        assign ge = sh >= den_reg[2];

        always_ff @(posedge clk)
        begin
            if (rdy[S_N3+1+j])
            begin
                a_r_reg[j+1] <= ge ? sh - den_reg[2] : sh;
                a_q_reg[j+1] <= {a_q_reg[j][QW-2:0], ge};
                a_m_reg[j+1] <= a_m_reg[j];
            end
        end
    end

    // ---------------------------------------------------------------
    // contact circle, distance and overlap test
    // ---------------------------------------------------------------
    logic [QW-1:0]         a_t;
    logic signed [QW:0]    a_qs;
    logic signed [SPW-1:0] a_pxq_reg;
    logic signed [SPW-1:0] a_pyq_reg;
    logic signed [RQW-1:0] a_rq_reg;
    logic [QW-1:0]         t4_reg;
    logic [QW-1:0]         t5_reg;
    logic [QW-1:0]         t6_reg;
    logic signed [W-1:0]   cx;
    logic signed [W-1:0]   cy;
    logic [W-2:0]          cr;
    logic signed [W-1:0]   cx_reg;
    logic signed [W-1:0]   cy_reg;
    logic [W-2:0]          cr_reg;
    logic signed [W-1:0]   cx6_reg;
    logic signed [W-1:0]   cy6_reg;
    logic [W-2:0]          cr6_reg;
    logic signed [DFW-1:0] bd_x_reg;
    logic signed [DFW-1:0] bd_y_reg;
    logic [W-1:0]          rsum_reg;
    logic signed [PRW-1:0] bsq_x_reg;
    logic signed [PRW-1:0] bsq_y_reg;
    logic [2*W-1:0]        lim_reg;
    logic [PRW-1:0]        bdist;

    logic                  hit_reg;
    logic signed [31:0]    cx_out_reg;
    logic signed [31:0]    cy_out_reg;
    logic [30:0]           cr_out_reg;
    logic [16:0]           t_out_reg;

    assign a_t   = proj_t(a_m_reg[F], a_q_reg[F]);
    assign a_qs  = $signed({1'b0, a_t});
    assign cx    = W'(DFW'(seg_sx[2]) + DFW'(a_pxq_reg >>> F));
    assign cy    = W'(DFW'(seg_sy[2]) + DFW'(a_pyq_reg >>> F));
    assign cr    = (W-1)'(W'({1'b0, rad_a}) + W'(a_rq_reg >>> F));
    assign bdist = $unsigned(bsq_x_reg) + $unsigned(bsq_y_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[S_P4])
        begin
            a_pxq_reg <= seg_abx[2] * a_qs;
            a_pyq_reg <= seg_aby[2] * a_qs;
            a_rq_reg  <= rad_diff * a_qs;
            t4_reg    <= a_t;
        end
        if (rdy[S_P5])
        begin
            cx_reg   <= cx;
            cy_reg   <= cy;
            cr_reg   <= cr;
            t5_reg   <= t4_reg;
            bd_x_reg <= DFW'(px_reg[S_P4]) - DFW'(cx);
            bd_y_reg <= DFW'(py_reg[S_P4]) - DFW'(cy);
            rsum_reg <= W'(pr_reg[S_P4]) + W'(cr);
        end
        if (rdy[S_P6])
        begin
            cx6_reg   <= cx_reg;
            cy6_reg   <= cy_reg;
            cr6_reg   <= cr_reg;
            t6_reg    <= t5_reg;
            bsq_x_reg <= bd_x_reg * bd_x_reg;
            bsq_y_reg <= bd_y_reg * bd_y_reg;
            lim_reg   <= (2*W)'(rsum_reg) * (2*W)'(rsum_reg);
        end
        if (rdy[S_OUT])
        begin
            hit_reg    <= bdist < PRW'(lim_reg);
            cx_out_reg <= 32'(cx6_reg);
            cy_out_reg <= 32'(cy6_reg);
            cr_out_reg <= 31'(cr6_reg);
            t_out_reg  <= 17'(t6_reg);
        end
    end

    assign m_tdata = {(cbcc_pkg::OUT_TDATA_W - cbcc_pkg::OUT_USED_W)'(0),
                      t_out_reg, cr_out_reg, cy_out_reg, cx_out_reg, hit_reg};

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    logic [W-2:0] rad_lo;
    logic [W-2:0] rad_hi;

    assign rad_lo = (rad_a < rad_b) ? rad_a : rad_b;
    assign rad_hi = (rad_a < rad_b) ? rad_b : rad_a;

    `CBCC_ASSERT_SAME(a_t_range, v_reg[S_OUT], t6_reg <= ONE || !v_reg[S_P6],
        "axis parameter above one")
    `CBCC_ASSERT_SAME(a_radius_between_ends, v_reg[S_P6],
        cr6_reg >= rad_lo && cr6_reg <= rad_hi, "contact radius outside end radii")
    `CBCC_ASSERT_SAME(a_full_stall, (&v_reg) && !m_tready, !s_tready,
        "request taken while pipeline is full and stalled")
    `CBCC_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v_reg[S_IN],
        "accepted request missing from first stage")

endmodule

@@ dv/capsule_ball_contact_circle_top_test.sv @@
// self-checking test of the ball against capsule contact block over stream and apb ports
// needs cbcc_pkg and the capsule_ball_contact_circle_top rtl; carries its own contact predictor
module capsule_ball_contact_circle_top_test;

    typedef bit signed [127:0] wide_t;

    typedef struct {
        bit        hit;
        bit [31:0] cx;
        bit [31:0] cy;
        bit [30:0] cr;
        bit [16:0] t;
    } contact_t;

    // contact circle predictor and queue of contacts still owed by the block
    class contact_board;
        bit [63:0] regs [cbcc_pkg::NUM_REGS];
        contact_t  owed [$];
        int        errors;
        int        hits;
        int        checked;

        function void set_reg(cbcc_pkg::reg_idx_t idx, bit [63:0] v);
            regs[idx] = v;
        endfunction

        // magnitude product kept to 64 bits, then the sign applied over 128
        function wide_t mul(longint x, longint y);
            bit [63:0] ux;
            bit [63:0] uy;
            wide_t     r;
            ux = x < 0 ? -x : x;
            uy = y < 0 ? -y : y;
            r  = {64'b0, ux * uy};
            if ((x < 0) != (y < 0)) r = -r;
            return r;
        endfunction

        function longint lo_coord(bit [63:0] v);
            return longint'($signed(v[31:0]));
        endfunction

        function longint hi_coord(bit [63:0] v);
            return longint'($signed(v[63:32]));
        endfunction

        function longint end_rad(bit [31:0] v);
            return v > 32'h7fff_ffff ? 64'h7fff_ffff : longint'(v);
        endfunction

        // point onto segment with clamped parameter
        function void project(longint qx, longint qy, longint ax, longint ay,
                              longint bx, longint by, output longint t,
                              output longint ox, output longint oy);
            longint abx;
            longint aby;
            wide_t  num;
            wide_t  den;
            wide_t  rem;
            abx = bx - ax;
            aby = by - ay;
            num = mul(qx - ax, abx) + mul(qy - ay, aby);
            den = mul(abx, abx) + mul(aby, aby);
            t = 0;
            if (den == 0 || num <= 0)
                t = 0;
            else if (!(num < den))
                t = 64'd1 << 16;
            else
            begin
                rem = num;
                for (int i = 0; i < 16; i++)
                begin
                    rem = rem <<< 1;
                    t = t << 1;
                    if (!(rem < den))
                    begin
                        rem = rem - den;
                        t = t | 1;
                    end
                end
            end
            ox = ax + ((abx * t) >>> 16);
            oy = ay + ((aby * t) >>> 16);
        endfunction

        function void note_ball(bit [31:0] x, bit [31:0] y, bit [30:0] r);
            longint   px, py, t1, t2, t, ax, ay, bx, by, cx, cy, ra, rb, cr, rs;
            wide_t    d1, d2, dist2;
            contact_t c;
            px = longint'($signed(x));
            py = longint'($signed(y));
            project(px, py, lo_coord(regs[cbcc_pkg::REG_T1_START]),
                    hi_coord(regs[cbcc_pkg::REG_T1_START]),
                    lo_coord(regs[cbcc_pkg::REG_T1_END]),
                    hi_coord(regs[cbcc_pkg::REG_T1_END]), t1, ax, ay);
            project(px, py, lo_coord(regs[cbcc_pkg::REG_T2_START]),
                    hi_coord(regs[cbcc_pkg::REG_T2_START]),
                    lo_coord(regs[cbcc_pkg::REG_T2_END]),
                    hi_coord(regs[cbcc_pkg::REG_T2_END]), t2, bx, by);
            d1 = mul(px - ax, px - ax) + mul(py - ay, py - ay);
            d2 = mul(px - bx, px - bx) + mul(py - by, py - by);
            // a tie goes to tangent two
            if (!(d1 < d2))
            begin
                ax = bx;
                ay = by;
            end
            project(ax, ay, lo_coord(regs[cbcc_pkg::REG_END_A]),
                    hi_coord(regs[cbcc_pkg::REG_END_A]),
                    lo_coord(regs[cbcc_pkg::REG_END_B]),
                    hi_coord(regs[cbcc_pkg::REG_END_B]), t, cx, cy);
            ra = end_rad(regs[cbcc_pkg::REG_RADII][31:0]);
            rb = end_rad(regs[cbcc_pkg::REG_RADII][63:32]);
            cr = ra + (((rb - ra) * t) >>> 16);
            dist2 = mul(px - cx, px - cx) + mul(py - cy, py - cy);
            rs = longint'(r) + cr;
            c.hit = dist2 < mul(rs, rs);
            c.cx  = cx[31:0];
            c.cy  = cy[31:0];
            c.cr  = cr[30:0];
            c.t   = t[16:0];
            owed.push_back(c);
        endfunction

        function void check_result(bit [cbcc_pkg::OUT_TDATA_W-1:0] d);
            contact_t e;
            if (owed.size() == 0)
            begin
                $error("contact result with none owed: %h", d);
                errors++;
                return;
            end
            e = owed.pop_front();
            checked++;
            if (d[0]) hits++;
            if (d[0] != e.hit)
            begin
                $error("hit: expected %0d actual %0d", e.hit, d[0]);
                errors++;
            end
            if (d[32:1] != e.cx)
            begin
                $error("circle_x: expected %h actual %h", e.cx, d[32:1]);
                errors++;
            end
            if (d[64:33] != e.cy)
            begin
                $error("circle_y: expected %h actual %h", e.cy, d[64:33]);
                errors++;
            end
            if (d[95:65] != e.cr)
            begin
                $error("circle_r: expected %h actual %h", e.cr, d[95:65]);
                errors++;
            end
            if (d[112:96] != e.t)
            begin
                $error("axis_param: expected %h actual %h", e.t, d[112:96]);
                errors++;
            end
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic [cbcc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [cbcc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [cbcc_pkg::CFG_ADDR_W-1:0]  paddr = '0;
    logic [cbcc_pkg::CFG_DATA_W-1:0]  pwdata = '0;
    logic [cbcc_pkg::CFG_DATA_W-1:0]  prdata;
    logic                             pready;

    contact_board board = new();
    bit           quiet = 1'b0;
    int           stall_left = 0;
    int           sent = 0;

    capsule_ball_contact_circle_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stall bursts, check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) board.check_result(m_tdata);
        if (quiet)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 18);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(cbcc_pkg::reg_idx_t idx, bit [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= cbcc_pkg::CFG_ADDR_W'(idx * 8);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.set_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_ball(bit [31:0] x, bit [31:0] y, bit [30:0] r);
        int gap;
        s_tdata  <= {1'b0, r, y, x};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        board.note_ball(x, y, r);
        sent++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // let the pipe drain before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.owed.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic bit [31:0] near_coord();
        return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    endfunction

    function automatic bit [63:0] near_point();
        return {near_coord(), near_coord()};
    endfunction

    function automatic bit [63:0] wide_pick();
        case ($urandom_range(0, 5))
            0:       return 64'h0;
            1:       return 64'hffff_ffff_ffff_ffff;
            2:       return 64'h8000_0000_7fff_ffff;
            3:       return 64'h7fff_ffff_8000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_capsule(int kind);
        bit [63:0] t1s;
        bit [63:0] t1e;
        t1s = kind == 0 ? near_point() : wide_pick();
        t1e = kind == 0 ? near_point() : wide_pick();
        write_reg(cbcc_pkg::REG_END_A, kind == 0 ? near_point() : wide_pick());
        write_reg(cbcc_pkg::REG_END_B, kind == 0 ? near_point() : wide_pick());
        write_reg(cbcc_pkg::REG_RADII, kind == 0 ? {$urandom_range(0, 32'h0030_0000),
                                                    $urandom_range(0, 32'h0030_0000)}
                                                 : wide_pick());
        write_reg(cbcc_pkg::REG_T1_START, t1s);
        write_reg(cbcc_pkg::REG_T1_END, t1e);
        // sometimes identical tangents to force a tie, sometimes a degenerate one
        case ($urandom_range(0, 3))
            0:
            begin
                write_reg(cbcc_pkg::REG_T2_START, t1s);
                write_reg(cbcc_pkg::REG_T2_END, t1e);
            end
            1:
            begin
                write_reg(cbcc_pkg::REG_T2_START, t1s);
                write_reg(cbcc_pkg::REG_T2_END, t1s);
            end
            default:
            begin
                write_reg(cbcc_pkg::REG_T2_START, kind == 0 ? near_point() : wide_pick());
                write_reg(cbcc_pkg::REG_T2_END, kind == 0 ? near_point() : wide_pick());
            end
        endcase
    endtask

    task automatic random_balls(int n);
        bit [31:0] r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom;
            if ($urandom_range(0, 3) != 0)
                send_ball(near_coord(), near_coord(), 31'($urandom_range(0, 32'h0020_0000)));
            else
                send_ball($urandom, $urandom, r[30:0]);
        end
    endtask

    // stops a hung run
    initial
    begin
        #5_000_000;
        $display("capsule_ball_contact_circle_top test failed");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capsule: every segment has zero length
        send_ball(32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
        send_ball(32'h0, 32'h0, 31'h0);
        send_ball(32'hffff_ffff, 32'h0001_0000, 31'h0001_0000);
        drain();

        // straight capsule with a saturating far radius and matching tangents
        write_reg(cbcc_pkg::REG_END_A, 64'h0);
        write_reg(cbcc_pkg::REG_END_B, {32'h0, 32'h0064_0000});
        write_reg(cbcc_pkg::REG_RADII, {32'hffff_ffff, 32'h0005_0000});
        write_reg(cbcc_pkg::REG_T1_START, {32'h000a_0000, 32'h0});
        write_reg(cbcc_pkg::REG_T1_END, {32'h000a_0000, 32'h0064_0000});
        write_reg(cbcc_pkg::REG_T2_START, {32'h000a_0000, 32'h0});
        write_reg(cbcc_pkg::REG_T2_END, {32'h000a_0000, 32'h0064_0000});
        send_ball(32'hffec_0000, 32'h0, 31'h0001_0000);
        send_ball(32'h0096_0000, 32'h0, 31'h0);
        send_ball(32'h0032_0000, 32'h0, 31'h0);
        send_ball(32'h0032_0000, 32'h0014_0000, 31'h7fff_ffff);
        send_ball(32'h0000_0001, 32'h0000_0001, 31'h0);
        send_ball(32'h0063_ffff, 32'hffff_ffff, 31'h0000_8000);
        send_ball(32'h8000_0000, 32'h8000_0000, 31'h0);
        send_ball(32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
        send_ball(32'h8000_0000, 32'h7fff_ffff, 31'h5555_5555);
        send_ball(32'h7fff_ffff, 32'h8000_0000, 31'h2aaa_aaaa);
        send_ball(32'h0019_0000, 32'h000a_0000, 31'h0);
        drain();

        // random capsules, near ones for hits and wide ones for range
        for (int ph = 0; ph < 8; ph++)
        begin
            random_capsule(ph % 3 == 2 ? 1 : 0);
            if (ph == 7) quiet = 1'b1;
            random_balls(110);
            drain();
        end

        $display("checked %0d contact results from %0d balls, %0d hits, over 10 capsules",
                 board.checked, sent, board.hits);
        if (board.errors == 0)
            $display("capsule_ball_contact_circle_top test passed");
        else
            $display("capsule_ball_contact_circle_top test failed");
        $finish;
    end
endmodule
